// File: hw/rtl/lqm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lqm_pkg: link quality monitor shared types and constants
// Field widths, register codes, reset levels and the quality scaling
// constants used by the interfaces, the evaluator and the top level.
// ----------------------------------------------------------------------------
package lqm_pkg;

  // Item field widths
  localparam int ID_W   = 4;
  localparam int RSSI_W = 12;
  localparam int SNR_W  = 10;
  localparam int PER_W  = 10;
  localparam int QUAL_W = 11;

  // Per-node store
  localparam int NODE_COUNT = 16;
  localparam int NODE_IDX_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int RCHG_W     = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RSSI_ACTIVE = 3'd0,
    CFG_SNR_ACTIVE  = 3'd1,
    CFG_PER_ACTIVE  = 3'd2,
    CFG_RSSI_CHANGE = 3'd3,
    CFG_SNR_CHANGE  = 3'd4,
    CFG_PER_CHANGE  = 3'd5
  } cfg_idx_t;

  localparam logic signed [RSSI_W-1:0] RSSI_ACTIVE_RST = -12'sd850;
  localparam logic signed [SNR_W-1:0]  SNR_ACTIVE_RST  = 10'sd100;
  localparam logic [PER_W-1:0]         PER_ACTIVE_RST  = 10'd100;
  localparam logic [RCHG_W-1:0]        RSSI_CHANGE_RST = 11'd50;
  localparam logic [SNR_W-1:0]         SNR_CHANGE_RST  = 10'd30;
  localparam logic [PER_W-1:0]         PER_CHANGE_RST  = 10'd50;

  // Quality: N = 40*(r+1200) + 90*s + 27*(1000-p), q = floor(1024*N/90000).
  // For 0 < N < 90000, q = (N * QUAL_RECIP) >> QUAL_SHIFT exactly.
  localparam int N_W        = 20;
  localparam int N_LO_W     = 17;
  localparam int RECIP_W    = 25;
  localparam int PROD_W     = N_LO_W + RECIP_W;
  localparam int QUAL_SHIFT = 31;
  localparam logic [RECIP_W-1:0] QUAL_RECIP  = 25'd24433592;
  localparam logic signed [N_W-1:0] QUAL_FULL_N = 20'sd90000;
  localparam logic [QUAL_W-1:0] QUALITY_ONE = 11'd1024;
  localparam logic [QUAL_W-1:0] ROUTE_LIMIT = 11'd307;

  typedef struct packed {
    logic signed [RSSI_W-1:0] rssi_active;
    logic signed [SNR_W-1:0]  snr_active;
    logic [PER_W-1:0]         per_active;
    logic [RCHG_W-1:0]        rssi_trig;
    logic [SNR_W-1:0]         snr_trig;
    logic [PER_W-1:0]         per_trig;
  } cfg_t;

  typedef struct packed {
    logic [ID_W-1:0]          neighbor_id;
    logic signed [RSSI_W-1:0] rssi;
    logic signed [SNR_W-1:0]  snr;
    logic [PER_W-1:0]         per;
  } item_t;

  typedef struct packed {
    logic signed [RSSI_W-1:0] rssi;
    logic signed [SNR_W-1:0]  snr;
    logic [PER_W-1:0]         per;
  } metrics_t;

  typedef struct packed {
    logic              active;
    logic              update_needed;
    logic [QUAL_W-1:0] quality;
    logic              route_ok;
  } result_t;

endpackage
`default_nettype wire

// File: hw/rtl/lqm_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lqm_ifs: link quality monitor channels
// Measurement channel and result channel, each a valid/ready beat.
// ----------------------------------------------------------------------------
interface lqm_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [lqm_pkg::ID_W-1:0]             neighbor_id;
  logic signed [lqm_pkg::RSSI_W-1:0]    rssi_tenths;
  logic signed [lqm_pkg::SNR_W-1:0]     snr_tenths;
  logic [lqm_pkg::PER_W-1:0]            per_tenths;

  modport source (output valid, neighbor_id, rssi_tenths, snr_tenths, per_tenths,
                  input ready);
  modport sink   (input valid, neighbor_id, rssi_tenths, snr_tenths, per_tenths,
                  output ready);
endinterface

interface lqm_out_if;
  logic                         valid;
  logic                         ready;
  logic                         active;
  logic                         update_needed;
  logic [lqm_pkg::QUAL_W-1:0]   quality;
  logic                         route_ok;

  modport source (output valid, active, update_needed, quality, route_ok,
                  input ready);
  modport sink   (input valid, active, update_needed, quality, route_ok,
                  output ready);
endinterface
`default_nettype wire

// File: hw/rtl/lqm_eval.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lqm_eval: link quality evaluation
// Threshold checks, change detection against the stored metrics and the
// weighted quality for one measurement.
// ----------------------------------------------------------------------------
module lqm_eval (
  input  var lqm_pkg::item_t    item,
  input  var lqm_pkg::metrics_t prev,
  input  var lqm_pkg::cfg_t     cfg,
  output lqm_pkg::result_t      res
);

  logic                                active;
  logic                                update;
  logic signed [lqm_pkg::RSSI_W:0]     rssi_diff;
  logic signed [lqm_pkg::SNR_W:0]      snr_diff;
  logic signed [lqm_pkg::PER_W:0]      per_diff;
  logic [lqm_pkg::RSSI_W:0]            rssi_mag;
  logic [lqm_pkg::SNR_W:0]             snr_mag;
  logic [lqm_pkg::PER_W:0]             per_mag;
  logic signed [lqm_pkg::N_W-1:0]      n_sum;
  logic [lqm_pkg::PROD_W-1:0]          prod;
  logic [lqm_pkg::QUAL_W-1:0]          qual;

  always_comb begin
    active = (item.rssi > cfg.rssi_active) && (item.snr > cfg.snr_active) &&
             (item.per < cfg.per_active);

    rssi_diff = (lqm_pkg::RSSI_W+1)'(item.rssi) - (lqm_pkg::RSSI_W+1)'(prev.rssi);
    snr_diff  = (lqm_pkg::SNR_W+1)'(item.snr) - (lqm_pkg::SNR_W+1)'(prev.snr);
    per_diff  = $signed({1'b0, item.per}) - $signed({1'b0, prev.per});
    rssi_mag  = rssi_diff[lqm_pkg::RSSI_W] ? (lqm_pkg::RSSI_W+1)'(-rssi_diff)
                                           : (lqm_pkg::RSSI_W+1)'(rssi_diff);
    snr_mag   = snr_diff[lqm_pkg::SNR_W] ? (lqm_pkg::SNR_W+1)'(-snr_diff)
                                         : (lqm_pkg::SNR_W+1)'(snr_diff);
    per_mag   = per_diff[lqm_pkg::PER_W] ? (lqm_pkg::PER_W+1)'(-per_diff)
                                         : (lqm_pkg::PER_W+1)'(per_diff);

    update = (rssi_mag > (lqm_pkg::RSSI_W+1)'(cfg.rssi_trig)) ||
             (snr_mag  > (lqm_pkg::SNR_W+1)'(cfg.snr_trig)) ||
             (per_mag  > (lqm_pkg::PER_W+1)'(cfg.per_trig));

    // weighted sum in units of 1/90000
    n_sum = 20'sd40 * (lqm_pkg::N_W'(item.rssi) + 20'sd1200) +
            20'sd90 * lqm_pkg::N_W'(item.snr) +
            20'sd27 * (20'sd1000 - $signed(lqm_pkg::N_W'(item.per)));

    prod = lqm_pkg::PROD_W'(n_sum[lqm_pkg::N_LO_W-1:0]) *
           lqm_pkg::PROD_W'(lqm_pkg::QUAL_RECIP);

    if (!(update && active) || n_sum <= 0) begin
      qual = '0;
    end else if (n_sum >= lqm_pkg::QUAL_FULL_N) begin
      qual = lqm_pkg::QUALITY_ONE;
    end else begin
      qual = prod[lqm_pkg::QUAL_SHIFT +: lqm_pkg::QUAL_W];
    end

    res.active        = active;
    res.update_needed = update;
    res.quality       = qual;
    res.route_ok      = update && (qual > lqm_pkg::ROUTE_LIMIT);
  end

endmodule
`default_nettype wire

// File: hw/rtl/link_quality_monitor_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// link_quality_monitor_core: per-neighbor link quality monitor
// Checks each neighbor measurement against active levels, flags metric
// changes against the last stored values and scores the link.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one measurement per beat: neighbor id, RSSI, SNR and PER,
//   all in tenths. out_chan returns exactly one result beat per measurement,
//   in order: active, update_needed, quality (1/1024 units, 0..1024) and
//   route_ok.
//   The cfg port writes the six level registers; write only while idle.
//   Indexes beyond the register list are dropped.
// Timing:
//   A measurement is held in an input register, evaluated and loaded into
//   the result register, which offers it on out_chan. Throughput is one beat
//   per cycle while out_chan.ready stays high; the node table is a small
//   register file read and written in the same cycle, so back-to-back beats
//   to the same node see each other's update.
// Reset:
//   rst_n clears both stage valids, restores the level registers to their
//   defaults and clears the per-node valid bits, so every node reads as zero
//   metrics until first measured.
// Stall:
//   When out_chan.ready is low the result holds; one more beat still enters
//   the input register, then in_chan.ready drops until the result drains.
// ----------------------------------------------------------------------------
module link_quality_monitor_core (
  input  wire                                 clk,
  input  wire                                 rst_n,
  lqm_in_if.sink                              in_chan,
  lqm_out_if.source                           out_chan,
  input  wire                                 cfg_we,
  input  wire  [lqm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [lqm_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  // Level registers
  lqm_pkg::cfg_t cfg_r, cfg_nxt;

  // Input stage
  logic           s1_valid_r, s1_valid_nxt;
  lqm_pkg::item_t s1_item_r;

  // Result stage
  logic             out_valid_r, out_valid_nxt;
  lqm_pkg::result_t out_res_r;
  lqm_pkg::result_t eval_res;

  // Per-node store: payload without reset, valid bits cleared by reset
  lqm_pkg::metrics_t               node_metrics_r [lqm_pkg::NODE_COUNT];
  logic [lqm_pkg::NODE_COUNT-1:0]  node_valid_r;

  logic                            in_take;
  logic                            out_load;
  logic [lqm_pkg::NODE_IDX_W-1:0]  node_idx;
  logic                            node_hit;
  lqm_pkg::metrics_t               stored_metrics;
  lqm_pkg::metrics_t               new_metrics;

  // Advance the input stage into the result register when it is free or draining.
  assign out_load      = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || out_load;
  assign in_take       = in_chan.valid && in_chan.ready;

  // Look up the node; ids past the table compare against zero and store nothing.
  assign node_idx = lqm_pkg::NODE_IDX_W'(s1_item_r.neighbor_id);
  assign node_hit = (32'(s1_item_r.neighbor_id) < lqm_pkg::NODE_COUNT);

  always_comb begin
    stored_metrics = '0;
    if (node_hit && node_valid_r[node_idx]) begin
      stored_metrics = node_metrics_r[node_idx];
    end
    new_metrics.rssi = s1_item_r.rssi;
    new_metrics.snr  = s1_item_r.snr;
    new_metrics.per  = s1_item_r.per;
  end

  lqm_eval u_eval (
    .item (s1_item_r),
    .prev (stored_metrics),
    .cfg  (cfg_r),
    .res  (eval_res)
  );

  // Decode configuration writes.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        lqm_pkg::CFG_RSSI_ACTIVE: cfg_nxt.rssi_active = cfg_wdata[lqm_pkg::RSSI_W-1:0];
        lqm_pkg::CFG_SNR_ACTIVE:  cfg_nxt.snr_active  = cfg_wdata[lqm_pkg::SNR_W-1:0];
        lqm_pkg::CFG_PER_ACTIVE:  cfg_nxt.per_active  = cfg_wdata[lqm_pkg::PER_W-1:0];
        lqm_pkg::CFG_RSSI_CHANGE: cfg_nxt.rssi_trig   = cfg_wdata[lqm_pkg::RCHG_W-1:0];
        lqm_pkg::CFG_SNR_CHANGE:  cfg_nxt.snr_trig    = cfg_wdata[lqm_pkg::SNR_W-1:0];
        lqm_pkg::CFG_PER_CHANGE:  cfg_nxt.per_trig    = cfg_wdata[lqm_pkg::PER_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage valids: fill on a taken beat, drain on a load or a taken result.
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (out_load) begin
      s1_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rssi_active <= lqm_pkg::RSSI_ACTIVE_RST;
      cfg_r.snr_active  <= lqm_pkg::SNR_ACTIVE_RST;
      cfg_r.per_active  <= lqm_pkg::PER_ACTIVE_RST;
      cfg_r.rssi_trig   <= lqm_pkg::RSSI_CHANGE_RST;
      cfg_r.snr_trig    <= lqm_pkg::SNR_CHANGE_RST;
      cfg_r.per_trig    <= lqm_pkg::PER_CHANGE_RST;
      s1_valid_r        <= 1'b0;
      out_valid_r       <= 1'b0;
      node_valid_r      <= '0;
    end else begin
      cfg_r       <= cfg_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (out_load && node_hit) begin
        node_valid_r[node_idx] <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r.neighbor_id <= in_chan.neighbor_id;
      s1_item_r.rssi        <= in_chan.rssi_tenths;
      s1_item_r.snr         <= in_chan.snr_tenths;
      s1_item_r.per         <= in_chan.per_tenths;
    end
    if (out_load) begin
      out_res_r <= eval_res;
      if (node_hit) begin
        node_metrics_r[node_idx] <= new_metrics;
      end
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.active        = out_res_r.active;
  assign out_chan.update_needed = out_res_r.update_needed;
  assign out_chan.quality       = out_res_r.quality;
  assign out_chan.route_ok      = out_res_r.route_ok;

  // Assertions

  // A scored route needs an active, updated link with quality above the limit.
  a_route_implies_score: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.route_ok |->
      out_res_r.active && out_res_r.update_needed &&
      (out_res_r.quality > lqm_pkg::ROUTE_LIMIT))
    else $error("route_ok without active update and sufficient quality");

  // Nonzero quality only for active, updated links, never above full scale.
  a_quality_gated: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_res_r.quality != '0) |->
      out_res_r.active && out_res_r.update_needed &&
      (out_res_r.quality <= lqm_pkg::QUALITY_ONE))
    else $error("quality nonzero outside an active update or above full scale");

  // An input stage that cannot advance keeps its beat.
  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_load |=> s1_valid_r && $stable(s1_item_r))
    else $error("input stage lost a stalled beat");

  // Each load into the result register leaves a valid result behind.
  a_load_offers: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("loaded result not offered");

endmodule
`default_nettype wire

// File: tb/lqm_result_checker.sv
// ----------------------------------------------------------------------------
// lqm_result_checker: scoreboard for the link quality monitor
// Tracks the level registers and the per-node metric history from the
// observed beats, scores each accepted measurement and compares every
// result beat, field by field, against the oldest predicted result.
// ----------------------------------------------------------------------------
module lqm_result_checker
  import lqm_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst_n,
  lqm_in_if                    in_mon,
  lqm_out_if                   out_mon,
  input  wire                  cfg_we,
  input  wire [CFG_IDX_W-1:0]  cfg_index,
  input  wire [CFG_DATA_W-1:0] cfg_wdata,
  output int                   mismatches,
  output int                   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint SCORE_FULL = 90000;
  localparam int     REPORT_CAP = 200;

  cfg_t     levels;
  metrics_t node_prev [NODE_COUNT];
  result_t  pending_results [$];
  result_t  want;
  item_t    taken;
  int       fail_total = 0;

  assign mismatches = fail_total;

  function automatic longint spread(input longint a, input longint b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Score one measurement and update the node history it belongs to.
  function automatic result_t score_measurement(input item_t m);
    metrics_t prev;
    longint   r, s, p, n, q;
    logic     act, upd;
    result_t  res;
    prev = '0;
    if (m.neighbor_id < NODE_COUNT) prev = node_prev[m.neighbor_id];
    r = longint'($signed(m.rssi));
    s = longint'($signed(m.snr));
    p = longint'(m.per);
    act = (r > longint'($signed(levels.rssi_active))) &&
          (s > longint'($signed(levels.snr_active))) &&
          (p < longint'(levels.per_active));
    upd = (spread(r, longint'($signed(prev.rssi))) > longint'(levels.rssi_trig)) ||
          (spread(s, longint'($signed(prev.snr))) > longint'(levels.snr_trig)) ||
          (spread(p, longint'(prev.per)) > longint'(levels.per_trig));
    if (m.neighbor_id < NODE_COUNT) begin
      node_prev[m.neighbor_id] = '{rssi: m.rssi, snr: m.snr, per: m.per};
    end
    q = 0;
    if (upd && act) begin
      // weighted score scaled by 90000, then truncated to 1/1024 units
      n = 40 * (r + 1200) + 90 * s + 27 * (1000 - p);
      if (n > 0) begin
        q = (n * longint'(QUALITY_ONE)) / SCORE_FULL;
        if (q > longint'(QUALITY_ONE)) q = longint'(QUALITY_ONE);
      end
    end
    res.active        = act;
    res.update_needed = upd;
    res.quality       = QUAL_W'(q);
    res.route_ok      = upd && (q > longint'(ROUTE_LIMIT));
    return res;
  endfunction

  task automatic check_field(input string what, input logic [QUAL_W-1:0] exp_v,
                             input logic [QUAL_W-1:0] got_v);
    if (got_v !== exp_v) begin
      fail_total++;
      if (fail_total <= REPORT_CAP) begin
        $display("%0t mismatch on %s: expected %0d, actual %0d", $time, what, exp_v, got_v);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      levels = '{rssi_active: RSSI_ACTIVE_RST, snr_active: SNR_ACTIVE_RST,
                 per_active: PER_ACTIVE_RST, rssi_trig: RSSI_CHANGE_RST,
                 snr_trig: SNR_CHANGE_RST, per_trig: PER_CHANGE_RST};
      foreach (node_prev[i]) node_prev[i] = '0;
      pending_results.delete();
    end else begin
      // retire a result beat before taking a new measurement beat
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) begin
        if (pending_results.size() == 0) begin
          fail_total++;
          if (fail_total <= REPORT_CAP) begin
            $display("%0t unexpected result beat: expected none, actual %0b %0b %0d %0b",
                     $time, out_mon.active, out_mon.update_needed, out_mon.quality,
                     out_mon.route_ok);
          end
        end else begin
          want = pending_results.pop_front();
          check_field("active", QUAL_W'(want.active), QUAL_W'(out_mon.active));
          check_field("update_needed", QUAL_W'(want.update_needed),
                      QUAL_W'(out_mon.update_needed));
          check_field("quality", want.quality, out_mon.quality);
          check_field("route_ok", QUAL_W'(want.route_ok), QUAL_W'(out_mon.route_ok));
        end
      end
      if (cfg_we === 1'b1) begin
        case (cfg_idx_t'(cfg_index))
          CFG_RSSI_ACTIVE: levels.rssi_active = cfg_wdata[RSSI_W-1:0];
          CFG_SNR_ACTIVE:  levels.snr_active  = cfg_wdata[SNR_W-1:0];
          CFG_PER_ACTIVE:  levels.per_active  = cfg_wdata[PER_W-1:0];
          CFG_RSSI_CHANGE: levels.rssi_trig   = cfg_wdata[RCHG_W-1:0];
          CFG_SNR_CHANGE:  levels.snr_trig    = cfg_wdata[SNR_W-1:0];
          CFG_PER_CHANGE:  levels.per_trig    = cfg_wdata[PER_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1) begin
        taken.neighbor_id = in_mon.neighbor_id;
        taken.rssi        = in_mon.rssi_tenths;
        taken.snr         = in_mon.snr_tenths;
        taken.per         = in_mon.per_tenths;
        pending_results.push_back(score_measurement(taken));
      end
    end
    outstanding <= pending_results.size();
  end

endmodule

// File: tb/tb_link_quality_monitor_core.sv
// ----------------------------------------------------------------------------
// tb_link_quality_monitor_core: testbench top for the link quality monitor
// Drives measurement beats and level register writes, pulls result beats
// with random back-pressure and leaves scoring to the checker beside the
// block. Directed corner points come first, then phases of shaped random
// measurements under several level settings.
// ----------------------------------------------------------------------------
module tb_link_quality_monitor_core;
  timeunit 1ns;
  timeprecision 1ps;
  import lqm_pkg::*;

  localparam int CLK_HALF      = 10;
  localparam int RESET_CYCLES  = 3;
  localparam int DRAIN_CYCLES  = 4;
  localparam int LONG_HOLD     = 80;
  localparam int PHASE_ITEMS   = 200;
  localparam int RANDOM_PHASES = 9;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int GAP_MAX       = 5;
  localparam int SPARE_INDEX   = int'(CFG_PER_CHANGE) + 1;

  typedef enum int {
    LEVELS_DEFAULT,
    LEVELS_LOOSE,
    LEVELS_TIGHT,
    LEVELS_MIXED
  } level_style_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    mismatches;
  int                    outstanding;
  int                    cycles = 0;
  int                    send_gap_max = GAP_MAX;
  int                    take_gap_max = GAP_MAX;
  bit                    hold_armed = 1'b0;

  // Shadow of the levels and of the last beat per node, used only to aim
  // random measurements at thresholds and change triggers.
  cfg_t     lvl;
  metrics_t last_sent [NODE_COUNT];

  lqm_in_if  in_chan ();
  lqm_out_if out_chan ();

  link_quality_monitor_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  lqm_result_checker result_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_chan),
    .out_mon     (out_chan),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #(CLK_HALF) clk = ~clk;

  // Watchdog: end the run if the traffic stops draining.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Result side: pick a stall per beat, then hold ready until a beat moves.
  // An armed hold replaces one stall with a long stretch so the block fills
  // and pushes back on the measurement side.
  initial begin : result_sink
    int stall;
    out_chan.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_armed) begin
        stall = LONG_HOLD;
        hold_armed = 1'b0;
      end else begin
        stall = (take_gap_max > 0) ? $urandom_range(0, take_gap_max) : 0;
      end
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (out_chan.valid !== 1'b1);
    end
  end

  // Offer one measurement beat after a random gap and hold it until taken.
  task automatic send_measurement(input item_t m);
    int gap;
    gap = (send_gap_max > 0) ? $urandom_range(0, send_gap_max) : 0;
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.neighbor_id <= m.neighbor_id;
    in_chan.rssi_tenths <= m.rssi;
    in_chan.snr_tenths  <= m.snr;
    in_chan.per_tenths  <= m.per;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    if (m.neighbor_id < NODE_COUNT) begin
      last_sent[m.neighbor_id] = '{rssi: m.rssi, snr: m.snr, per: m.per};
    end
  endtask

  task automatic send_point(input int id, input int r, input int s, input int p);
    item_t m;
    m.neighbor_id = ID_W'(id);
    m.rssi        = RSSI_W'(r);
    m.snr         = SNR_W'(s);
    m.per         = PER_W'(p);
    send_measurement(m);
  endtask

  // Drop valid, wait for every predicted result, then let the pipe settle.
  task automatic drain_results();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_level(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (cfg_idx_t'(idx))
      CFG_RSSI_ACTIVE: lvl.rssi_active = val[RSSI_W-1:0];
      CFG_SNR_ACTIVE:  lvl.snr_active  = val[SNR_W-1:0];
      CFG_PER_ACTIVE:  lvl.per_active  = val[PER_W-1:0];
      CFG_RSSI_CHANGE: lvl.rssi_trig   = val[RCHG_W-1:0];
      CFG_SNR_CHANGE:  lvl.snr_trig    = val[SNR_W-1:0];
      CFG_PER_CHANGE:  lvl.per_trig    = val[PER_W-1:0];
      default: ;
    endcase
  endtask

  // Keep the register's own bits, fill the unused upper bits with noise.
  function automatic logic [CFG_DATA_W-1:0] padded(input logic [CFG_DATA_W-1:0] field,
                                                   input int width);
    logic [CFG_DATA_W-1:0] v;
    v = CFG_DATA_W'($urandom);
    for (int b = 0; b < width; b++) v[b] = field[b];
    return v;
  endfunction

  task automatic program_levels(input level_style_t style);
    cfg_idx_t idx;
    longint   lo, hi;
    int       width;
    case (style)
      LEVELS_DEFAULT: begin
        write_level(CFG_RSSI_ACTIVE, padded(CFG_DATA_W'(RSSI_ACTIVE_RST), RSSI_W));
        write_level(CFG_SNR_ACTIVE,  padded(CFG_DATA_W'(SNR_ACTIVE_RST), SNR_W));
        write_level(CFG_PER_ACTIVE,  padded(CFG_DATA_W'(PER_ACTIVE_RST), PER_W));
        write_level(CFG_RSSI_CHANGE, padded(CFG_DATA_W'(RSSI_CHANGE_RST), RCHG_W));
        write_level(CFG_SNR_CHANGE,  padded(CFG_DATA_W'(SNR_CHANGE_RST), SNR_W));
        write_level(CFG_PER_CHANGE,  padded(CFG_DATA_W'(PER_CHANGE_RST), PER_W));
      end
      LEVELS_LOOSE: begin
        // lowest active bars, zero change triggers
        write_level(CFG_RSSI_ACTIVE, padded(CFG_DATA_W'(-2048), RSSI_W));
        write_level(CFG_SNR_ACTIVE,  padded(CFG_DATA_W'(-512), SNR_W));
        write_level(CFG_PER_ACTIVE,  padded(CFG_DATA_W'(1023), PER_W));
        write_level(CFG_RSSI_CHANGE, padded(CFG_DATA_W'(0), RCHG_W));
        write_level(CFG_SNR_CHANGE,  padded(CFG_DATA_W'(0), SNR_W));
        write_level(CFG_PER_CHANGE,  padded(CFG_DATA_W'(0), PER_W));
      end
      LEVELS_TIGHT: begin
        // highest active bars, widest change triggers
        write_level(CFG_RSSI_ACTIVE, padded(CFG_DATA_W'(2047), RSSI_W));
        write_level(CFG_SNR_ACTIVE,  padded(CFG_DATA_W'(511), SNR_W));
        write_level(CFG_PER_ACTIVE,  padded(CFG_DATA_W'(0), PER_W));
        write_level(CFG_RSSI_CHANGE, padded(CFG_DATA_W'(2047), RCHG_W));
        write_level(CFG_SNR_CHANGE,  padded(CFG_DATA_W'(1023), SNR_W));
        write_level(CFG_PER_CHANGE,  padded(CFG_DATA_W'(1023), PER_W));
      end
      default: begin
        for (int i = 0; i <= int'(CFG_PER_CHANGE); i++) begin
          idx = cfg_idx_t'(i);
          case (idx)
            CFG_RSSI_ACTIVE: begin lo = -1280; hi = 0;    width = RSSI_W; end
            CFG_SNR_ACTIVE:  begin lo = -200;  hi = 500;  width = SNR_W;  end
            CFG_PER_ACTIVE:  begin lo = 0;     hi = 1000; width = PER_W;  end
            CFG_RSSI_CHANGE: begin lo = 0;     hi = 1280; width = RCHG_W; end
            CFG_SNR_CHANGE:  begin lo = 0;     hi = 700;  width = SNR_W;  end
            default:         begin lo = 0;     hi = 1000; width = PER_W;  end
          endcase
          // half the time any bit pattern, otherwise a realistic level
          if ($urandom_range(0, 1) == 1) begin
            write_level(idx, CFG_DATA_W'($urandom));
          end else begin
            write_level(idx, padded(CFG_DATA_W'(lo + longint'($urandom_range(0, int'(hi - lo)))),
                                    width));
          end
        end
      end
    endcase
    // a write past the register list must change nothing
    write_level(CFG_IDX_W'($urandom_range(SPARE_INDEX, (1 << CFG_IDX_W) - 1)),
                CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  function automatic longint near(input longint center, input longint reach);
    longint jitter;
    jitter = longint'($urandom_range(0, 4)) - 2;
    return (($urandom_range(0, 1) == 1) ? center + reach : center - reach) + jitter;
  endfunction

  // Aim a metric at its change trigger, at its active bar, or anywhere in range.
  function automatic longint shape_metric(input longint prev, input longint chg,
                                          input longint bar, input longint lo,
                                          input longint hi);
    case ($urandom_range(0, 2))
      0:       return near(prev, chg);
      1:       return near(bar, 0);
      default: return lo + longint'($urandom_range(0, int'(hi - lo)));
    endcase
  endfunction

  function automatic item_t random_measurement();
    item_t    m;
    metrics_t base;
    m.neighbor_id = ID_W'($urandom);
    if ($urandom_range(0, 9) == 0) begin
      // raw noise over the full field widths
      m.rssi = RSSI_W'($urandom);
      m.snr  = SNR_W'($urandom);
      m.per  = PER_W'($urandom);
    end else begin
      base   = last_sent[m.neighbor_id];
      m.rssi = RSSI_W'(shape_metric(longint'($signed(base.rssi)), longint'(lvl.rssi_trig),
                                    longint'($signed(lvl.rssi_active)), -1280, 0));
      m.snr  = SNR_W'(shape_metric(longint'($signed(base.snr)), longint'(lvl.snr_trig),
                                   longint'($signed(lvl.snr_active)), -200, 500));
      m.per  = PER_W'(shape_metric(longint'(base.per), longint'(lvl.per_trig),
                                   longint'(lvl.per_active), 0, 1000));
    end
    return m;
  endfunction

  initial begin
    in_chan.valid       <= 1'b0;
    in_chan.neighbor_id <= '0;
    in_chan.rssi_tenths <= '0;
    in_chan.snr_tenths  <= '0;
    in_chan.per_tenths  <= '0;
    cfg_we              <= 1'b0;
    cfg_index           <= '0;
    cfg_wdata           <= '0;
    rst_n               <= 1'b0;
    lvl = '{rssi_active: RSSI_ACTIVE_RST, snr_active: SNR_ACTIVE_RST,
            per_active: PER_ACTIVE_RST, rssi_trig: RSSI_CHANGE_RST,
            snr_trig: SNR_CHANGE_RST, per_trig: PER_CHANGE_RST};
    foreach (last_sent[i]) last_sent[i] = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Reset levels. First beat of a node compares against cleared history.
    send_point(0, 0, 0, 0);          // no change from cleared entry, inactive
    send_point(0, 0, 0, 0);          // repeat on the same node
    send_point(1, 0, 500, 0);        // best link: score clamps at full scale
    send_point(1, 0, 500, 0);        // active but unchanged: score forced to zero
    send_point(1, -50, 500, 0);      // RSSI change equal to trigger: no update
    send_point(1, -101, 500, 0);     // one past the trigger: update
    send_point(2, -850, 101, 99);    // RSSI equal to its bar: not active
    send_point(2, -849, 100, 99);    // SNR equal to its bar: not active
    send_point(2, -849, 101, 100);   // PER equal to its bar: not active
    send_point(3, -849, 101, 99);    // just inside every bar
    send_point(4, -1280, -200, 1000);
    send_point(5, -2048, -512, 1023); // metrics past their stated ranges
    send_point(6, 2047, 511, 0);
    send_point(15, -30, 31, 51);     // top node id, SNR just past trigger
    send_point(15, -30, 31, 51);
    send_point(15, -30, 31, 0);      // PER change alone flags the update
    drain_results();

    // Loose levels: reach the route threshold and a negative raw score.
    program_levels(LEVELS_LOOSE);
    send_point(7, -2047, -511, 1022); // raw score below zero clamps to zero
    send_point(8, -1200, 0, 0);      // score lands on the route threshold
    send_point(9, -1198, 0, 0);      // one step above the route threshold
    send_point(8, -1200, 0, 0);      // zero triggers, zero change: no update
    send_point(10, -2048, 0, 0);     // RSSI equal to lowest bar
    send_point(11, 0, 0, 1023);      // PER equal to highest bar
    drain_results();

    // Tight levels: change exactly at and one past the widest triggers.
    program_levels(LEVELS_TIGHT);
    send_point(12, -2048, -512, 0);
    send_point(13, 2047, 511, 1023);

    // Random phases: rotate level settings and idling styles, with a long
    // result-side hold in two of them.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain_results();
      if (ph == 0) program_levels(LEVELS_DEFAULT);
      else if (ph == 1) program_levels(LEVELS_LOOSE);
      else if (ph == 2) program_levels(LEVELS_TIGHT);
      else program_levels(LEVELS_MIXED);
      send_gap_max = (ph % 3 == 1) ? 0 : GAP_MAX;
      take_gap_max = (ph % 3 == 2) ? 0 : GAP_MAX;
      if (ph == 4 || ph == 7) hold_armed = 1'b1;
      repeat (PHASE_ITEMS) send_measurement(random_measurement());
    end
    drain_results();

    if (mismatches == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
